FILE: hdl/k_nearest_neighbor_select_macros.svh
// Assertion macros used by the k-nearest-neighbor select top level.
`ifndef K_NEAREST_NEIGHBOR_SELECT_MACROS_SVH
`define K_NEAREST_NEIGHBOR_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KNN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("knn check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KNN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("knn check failed");

`endif

FILE: hdl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor select block.
`default_nettype none

package knn_pkg;

  // Width of the reported neighbor index.
  localparam int unsigned RESULT_INDEX_BITS = 16;

  // Candidate queue between distance front end and list back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Pipeline registers in the distance front end.
  localparam int unsigned FRONT_STAGES = 2;

  // Width of the in-flight word count (queue plus front stages).
  localparam int unsigned OCC_BITS = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

  // Control tag that travels with every candidate word.
  typedef struct packed {
    logic valid;
    logic skip;
    logic last;
  } ctrl_t;

  typedef enum logic [0:0] {
    BK_RUN,
    BK_EMIT
  } back_state_e;

endpackage

`default_nettype wire

FILE: hdl/knn_front.sv
// Front end: index check and squared-distance pipeline for each candidate.
`default_nettype none

module knn_front #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned DIST_BITS  = 2 * COORD_BITS + 2
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  input  wire        [INDEX_BITS-1:0]  query_index_i,
  input  wire signed [COORD_BITS-1:0]  query_x_i,
  input  wire signed [COORD_BITS-1:0]  query_y_i,
  input  wire signed [COORD_BITS-1:0]  query_z_i,
  input  wire        [INDEX_BITS-1:0]  cand_index_i,
  input  wire signed [COORD_BITS-1:0]  cand_x_i,
  input  wire signed [COORD_BITS-1:0]  cand_y_i,
  input  wire signed [COORD_BITS-1:0]  cand_z_i,
  input  wire                          last_candidate_i,
  output knn_pkg::ctrl_t               push_o,
  output logic       [DIST_BITS-1:0]   dist_o,
  output logic       [INDEX_BITS-1:0]  index_o,
  output logic [knn_pkg::FRONT_STAGES-1:0] pipe_vld_o
);

  localparam int unsigned SQ_BITS = 2 * COORD_BITS;

  knn_pkg::ctrl_t s1_q, s2_q;
  logic [INDEX_BITS-1:0] s1_idx_q, s2_idx_q;
  logic [COORD_BITS-1:0] ax_q, ay_q, az_q;
  logic [COORD_BITS-1:0] ax_d, ay_d, az_d;
  logic [SQ_BITS-1:0]    sx_q, sy_q, sz_q;
  logic [COORD_BITS:0]   dx, dy, dz;
  logic [COORD_BITS:0]   ndx, ndy, ndz;

  // Subtract with one guard bit, then take the magnitude.
  assign dx  = {query_x_i[COORD_BITS-1], query_x_i} - {cand_x_i[COORD_BITS-1], cand_x_i};
  assign dy  = {query_y_i[COORD_BITS-1], query_y_i} - {cand_y_i[COORD_BITS-1], cand_y_i};
  assign dz  = {query_z_i[COORD_BITS-1], query_z_i} - {cand_z_i[COORD_BITS-1], cand_z_i};
  assign ndx = ~dx + (COORD_BITS + 1)'(1);
  assign ndy = ~dy + (COORD_BITS + 1)'(1);
  assign ndz = ~dz + (COORD_BITS + 1)'(1);
  assign ax_d = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay_d = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign az_d = dz[COORD_BITS] ? ndz[COORD_BITS-1:0] : dz[COORD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q.valid <= in_valid_i;
      s1_q.skip  <= (cand_index_i == query_index_i);
      s1_q.last  <= last_candidate_i;
      s2_q       <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    az_q     <= az_d;
    s1_idx_q <= cand_index_i;
    sx_q     <= SQ_BITS'(ax_q) * SQ_BITS'(ax_q);
    sy_q     <= SQ_BITS'(ay_q) * SQ_BITS'(ay_q);
    sz_q     <= SQ_BITS'(az_q) * SQ_BITS'(az_q);
    s2_idx_q <= s1_idx_q;
  end

  // Magnitudes stay below 2^COORD_BITS, so the sum of squares cannot overflow.
  assign dist_o     = DIST_BITS'(sx_q) + DIST_BITS'(sy_q) + DIST_BITS'(sz_q);
  assign index_o    = s2_idx_q;
  assign push_o     = s2_q;
  assign pipe_vld_o = {s2_q.valid, s1_q.valid};

endmodule

`default_nettype wire

FILE: hdl/knn_queue.sv
// Short queue of candidate words between front end and list back end.
`default_nettype none

module knn_queue #(
  parameter int unsigned DATA_BITS = 68,
  parameter int unsigned DEPTH     = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  knn_pkg::ctrl_t         push_i,
  input  wire  [DATA_BITS-1:0]   push_data_i,
  input  wire                    pop_i,
  output knn_pkg::ctrl_t         head_o,
  output logic [DATA_BITS-1:0]   head_data_o,
  output logic [knn_pkg::QUEUE_CNT_BITS-1:0] count_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_BITS-1:0] data_q [DEPTH];
  logic [DEPTH-1:0]     skip_q, last_q;
  logic [PTR_BITS-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [knn_pkg::QUEUE_CNT_BITS-1:0] count_q, count_d;
  logic                 do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i.valid) begin
      wptr_d = (wptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_q + PTR_BITS'(1);
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + knn_pkg::QUEUE_CNT_BITS'(1);
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - knn_pkg::QUEUE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      data_q[wptr_q] <= push_data_i;
      skip_q[wptr_q] <= push_i.skip;
      last_q[wptr_q] <= push_i.last;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.skip  = skip_q[rptr_q];
  assign head_o.last  = last_q[rptr_q];
  assign head_data_o  = data_q[rptr_q];
  assign count_o      = count_q;

endmodule

`default_nettype wire

FILE: hdl/knn_list.sv
// Back end: sorted insertion cells and the result emitter.
`default_nettype none

module knn_list #(
  parameter int unsigned NEIGHBOR_COUNT = 12,
  parameter int unsigned INDEX_BITS     = 16,
  parameter int unsigned DIST_BITS      = 50
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  knn_pkg::ctrl_t         head_i,
  input  wire  [DIST_BITS-1:0]   head_dist_i,
  input  wire  [INDEX_BITS-1:0]  head_index_i,
  output logic                   pop_o,
  output logic                   result_valid_o,
  output logic [knn_pkg::RESULT_INDEX_BITS-1:0] neighbor_index_o,
  output logic                   found_o,
  output logic                   last_of_list_o
);

  localparam int unsigned CNT_BITS = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;
  localparam int unsigned RIB      = knn_pkg::RESULT_INDEX_BITS;
  localparam int unsigned WIDE_BITS = (INDEX_BITS > RIB) ? INDEX_BITS : RIB;

  knn_pkg::back_state_e state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  emit, do_ins, cnt_end;

  logic [DIST_BITS-1:0]  dist_q [NEIGHBOR_COUNT];
  logic [DIST_BITS-1:0]  dist_d [NEIGHBOR_COUNT];
  logic [INDEX_BITS-1:0] idx_q  [NEIGHBOR_COUNT];
  logic [INDEX_BITS-1:0] idx_d  [NEIGHBOR_COUNT];
  logic [NEIGHBOR_COUNT-1:0] vld_q, vld_d, ins;

  logic                  res_valid_q, res_found_q, res_last_q;
  logic [RIB-1:0]        res_idx_q;
  logic [WIDE_BITS-1:0]  head_wide;

  assign cnt_end = (cnt_q == CNT_BITS'(NEIGHBOR_COUNT - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      knn_pkg::BK_RUN: begin
        if (head_i.valid && head_i.last) begin
          state_d = knn_pkg::BK_EMIT;
        end
      end
      knn_pkg::BK_EMIT: begin
        if (cnt_end) begin
          state_d = knn_pkg::BK_RUN;
        end
      end
      default: state_d = knn_pkg::BK_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    case (state_q)
      knn_pkg::BK_RUN:  pop_o = head_i.valid;
      knn_pkg::BK_EMIT: emit  = 1'b1;
      default: begin
        pop_o = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  assign do_ins = pop_o && !head_i.skip;
  assign cnt_d  = emit ? (cnt_end ? '0 : cnt_q + CNT_BITS'(1)) : cnt_q;

  // A cell takes the new word if it is empty or holds a strictly larger distance;
  // ties keep the earlier word ahead.
  always_comb begin
    for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
      ins[k] = !vld_q[k] || (dist_q[k] > head_dist_i);
    end
  end

  always_comb begin
    logic                  p_ins, p_vld;
    logic [DIST_BITS-1:0]  p_dist;
    logic [INDEX_BITS-1:0] p_idx;
    p_ins  = 1'b0;
    p_vld  = 1'b1;
    p_dist = head_dist_i;
    p_idx  = head_index_i;
    for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
      dist_d[k] = dist_q[k];
      idx_d[k]  = idx_q[k];
      vld_d[k]  = vld_q[k];
      if (do_ins && ins[k]) begin
        // First inserting cell takes the new word, the rest shift down by one.
        dist_d[k] = p_ins ? p_dist : head_dist_i;
        idx_d[k]  = p_ins ? p_idx : head_index_i;
        vld_d[k]  = vld_q[k] | p_vld;
      end
      p_ins  = ins[k];
      p_vld  = vld_q[k];
      p_dist = dist_q[k];
      p_idx  = idx_q[k];
    end
    if (emit) begin
      // Advance the list toward cell 0; the tail empties.
      p_vld  = 1'b0;
      p_dist = '0;
      p_idx  = '0;
      for (int k = NEIGHBOR_COUNT - 1; k >= 0; k--) begin
        dist_d[k] = p_dist;
        idx_d[k]  = p_idx;
        vld_d[k]  = p_vld;
        p_vld     = vld_q[k];
        p_dist    = dist_q[k];
        p_idx     = idx_q[k];
      end
    end
  end

  assign head_wide = WIDE_BITS'(idx_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= knn_pkg::BK_RUN;
      cnt_q       <= '0;
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      vld_q       <= vld_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
      dist_q[k] <= dist_d[k];
      idx_q[k]  <= idx_d[k];
    end
    res_found_q <= vld_q[0];
    res_idx_q   <= vld_q[0] ? head_wide[RIB-1:0] : '0;
    res_last_q  <= cnt_end;
  end

  assign result_valid_o   = res_valid_q;
  assign neighbor_index_o = res_idx_q;
  assign found_o          = res_found_q;
  assign last_of_list_o   = res_last_q;

endmodule

`default_nettype wire

FILE: hdl/k_nearest_neighbor_select.sv
// Top level of the k-nearest-neighbor select block.
//
// Usage: drive one candidate per cycle on the input ports with start_i high;
// a word is taken at a rising edge where start_i is high and busy_o is low.
// Each word names a query and one candidate; a candidate with the query's own
// index is dropped. Mark the final candidate of a query with last_candidate_i.
// After that word reaches the list, NEIGHBOR_COUNT results leave on
// consecutive cycles, nearest first, each marked by result_valid_o for one
// cycle; unfilled ranks give found_o low and index zero, and last_of_list_o
// flags the final rank. The list is then empty for the next query.
// The block takes one candidate per cycle while busy_o is low, as the insertion
// cells take one word per cycle outside emission; at each list end the back end
// emits its results and pops no word while the front end keeps filling the queue.
// With an empty queue, the last candidate passes the second distance stage, the
// queue write, the list insert and the result register before the first result
// is on the ports.
// busy_o rises when the queue and distance stages hold QUEUE_DEPTH words.
// Results cannot be held off by the receiver. Reset empties queue and list.
`default_nettype none
`include "k_nearest_neighbor_select_macros.svh"

module k_nearest_neighbor_select #(
  parameter int unsigned NEIGHBOR_COUNT = 12,
  parameter int unsigned INDEX_BITS     = 16,
  parameter int unsigned COORD_BITS     = 24
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire        [INDEX_BITS-1:0]  query_index_i,
  input  wire signed [COORD_BITS-1:0]  query_x_i,
  input  wire signed [COORD_BITS-1:0]  query_y_i,
  input  wire signed [COORD_BITS-1:0]  query_z_i,
  input  wire        [INDEX_BITS-1:0]  cand_index_i,
  input  wire signed [COORD_BITS-1:0]  cand_x_i,
  input  wire signed [COORD_BITS-1:0]  cand_y_i,
  input  wire signed [COORD_BITS-1:0]  cand_z_i,
  input  wire                          last_candidate_i,
  output logic                         result_valid_o,
  output logic [knn_pkg::RESULT_INDEX_BITS-1:0] neighbor_index_o,
  output logic                         found_o,
  output logic                         last_of_list_o
);

  localparam int unsigned DIST_BITS = 2 * COORD_BITS + 2;
  localparam int unsigned WORD_BITS = DIST_BITS + INDEX_BITS;

  knn_pkg::ctrl_t        push, head;
  logic [DIST_BITS-1:0]  push_dist;
  logic [INDEX_BITS-1:0] push_index;
  logic [WORD_BITS-1:0]  head_word;
  logic [knn_pkg::FRONT_STAGES-1:0]   pipe_vld;
  logic [knn_pkg::QUEUE_CNT_BITS-1:0] q_count;
  logic [knn_pkg::OCC_BITS-1:0]       occ;
  logic                  pop, accept;

  // Count queued words plus words still in the distance stages.
  always_comb begin
    occ = knn_pkg::OCC_BITS'(q_count);
    for (int s = 0; s < knn_pkg::FRONT_STAGES; s++) begin
      occ = occ + knn_pkg::OCC_BITS'(pipe_vld[s]);
    end
  end

  assign busy_o = (occ >= knn_pkg::OCC_BITS'(knn_pkg::QUEUE_DEPTH));
  assign accept = start_i && !busy_o;

  knn_front #(
    .INDEX_BITS (INDEX_BITS),
    .COORD_BITS (COORD_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (accept),
    .query_index_i    (query_index_i),
    .query_x_i        (query_x_i),
    .query_y_i        (query_y_i),
    .query_z_i        (query_z_i),
    .cand_index_i     (cand_index_i),
    .cand_x_i         (cand_x_i),
    .cand_y_i         (cand_y_i),
    .cand_z_i         (cand_z_i),
    .last_candidate_i (last_candidate_i),
    .push_o           (push),
    .dist_o           (push_dist),
    .index_o          (push_index),
    .pipe_vld_o       (pipe_vld)
  );

  knn_queue #(
    .DATA_BITS (WORD_BITS),
    .DEPTH     (knn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_dist, push_index}),
    .pop_i       (pop),
    .head_o      (head),
    .head_data_o (head_word),
    .count_o     (q_count)
  );

  knn_list #(
    .NEIGHBOR_COUNT (NEIGHBOR_COUNT),
    .INDEX_BITS     (INDEX_BITS),
    .DIST_BITS      (DIST_BITS)
  ) u_list (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_dist_i      (head_word[WORD_BITS-1:INDEX_BITS]),
    .head_index_i     (head_word[INDEX_BITS-1:0]),
    .pop_o            (pop),
    .result_valid_o   (result_valid_o),
    .neighbor_index_o (neighbor_index_o),
    .found_o          (found_o),
    .last_of_list_o   (last_of_list_o)
  );

  // The credit count keeps the queue from overrunning.
  `KNN_ASSERT_NOW(a_queue_bound, clk_i, rst_ni, 1'b1,
    q_count <= knn_pkg::QUEUE_CNT_BITS'(knn_pkg::QUEUE_DEPTH))

  // Filled ranks come first: once a rank is empty, the rest of the list is too.
  `KNN_ASSERT_NEXT(a_found_prefix, clk_i, rst_ni,
    result_valid_o && !found_o && !last_of_list_o, result_valid_o && !found_o)

  // A list runs without gaps, and result_valid_o drops after its final rank.
  `KNN_ASSERT_NEXT(a_list_end_gap, clk_i, rst_ni,
    result_valid_o && last_of_list_o, !result_valid_o)

endmodule

`default_nettype wire

FILE: bench/tb_k_nearest_neighbor_select.sv
// Self-checking testbench for the k-nearest-neighbor select block.
`default_nettype none

module tb_k_nearest_neighbor_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NEIGHBOR_COUNT = 12;
  localparam int unsigned INDEX_BITS     = 16;
  localparam int unsigned COORD_BITS     = 24;
  localparam int unsigned RES_BITS       = knn_pkg::RESULT_INDEX_BITS;
  localparam int unsigned RAND_ITEMS     = 150;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned DIR_ROWS       = 22;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;

  typedef enum int unsigned {
    CM_FULL,
    CM_SMALL,
    CM_MAX,
    CM_MIN
  } coord_mode_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        query_index;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
    logic [INDEX_BITS-1:0]        cand_index;
    logic signed [COORD_BITS-1:0] cand_x;
    logic signed [COORD_BITS-1:0] cand_y;
    logic signed [COORD_BITS-1:0] cand_z;
    logic                         last;
  } cand_word_t;

  typedef struct packed {
    logic [RES_BITS-1:0] index;
    logic                found;
    logic                last;
  } rank_t;

  // typed = 1: at most one neighbor kept, expectation given in the row
  typedef struct packed {
    cand_word_t          word;
    logic                typed;
    logic                t_found;
    logic [RES_BITS-1:0] t_index;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [INDEX_BITS-1:0]        query_index_i;
  logic signed [COORD_BITS-1:0] query_x_i;
  logic signed [COORD_BITS-1:0] query_y_i;
  logic signed [COORD_BITS-1:0] query_z_i;
  logic [INDEX_BITS-1:0]        cand_index_i;
  logic signed [COORD_BITS-1:0] cand_x_i;
  logic signed [COORD_BITS-1:0] cand_y_i;
  logic signed [COORD_BITS-1:0] cand_z_i;
  logic last_candidate_i;
  logic result_valid_o;
  logic [RES_BITS-1:0] neighbor_index_o;
  logic found_o;
  logic last_of_list_o;

  // kept list of the nearest candidates, mirrored from the block
  longint unsigned       near_dist [NEIGHBOR_COUNT];
  logic [INDEX_BITS-1:0] near_idx  [NEIGHBOR_COUNT];
  int unsigned           near_cnt;
  rank_t                 ranked    [NEIGHBOR_COUNT];

  rank_t       pending_ranks[$];
  int unsigned mismatch_cnt;
  int unsigned burst_left;

  k_nearest_neighbor_select #(
    .NEIGHBOR_COUNT(NEIGHBOR_COUNT),
    .INDEX_BITS    (INDEX_BITS),
    .COORD_BITS    (COORD_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .query_index_i   (query_index_i),
    .query_x_i       (query_x_i),
    .query_y_i       (query_y_i),
    .query_z_i       (query_z_i),
    .cand_index_i    (cand_index_i),
    .cand_x_i        (cand_x_i),
    .cand_y_i        (cand_y_i),
    .cand_z_i        (cand_z_i),
    .last_candidate_i(last_candidate_i),
    .result_valid_o  (result_valid_o),
    .neighbor_index_o(neighbor_index_o),
    .found_o         (found_o),
    .last_of_list_o  (last_of_list_o)
  );

  always #4 clk_i = ~clk_i;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // self candidate marked last right after reset: empty list
    '{'{16'd5, 24'sd0, 24'sd0, 24'sd0, 16'd5, 24'sd7, 24'sd7, 24'sd7, 1'b1},
      1'b1, 1'b0, 16'd0},
    // corner to corner, widest distance
    '{'{16'h0000, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, COORD_MIN, COORD_MIN,
        COORD_MIN, 1'b1}, 1'b1, 1'b1, 16'hFFFF},
    '{'{16'hFFFF, COORD_MIN, COORD_MAX, COORD_MIN, 16'h0000, COORD_MAX, COORD_MIN,
        COORD_MAX, 1'b1}, 1'b1, 1'b1, 16'h0000},
    // one query, ties, a skipped self, overfill, drop at full list
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd1, 24'sd10, 24'sd0, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd2, 24'sd5, 24'sd0, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd3, -24'sd5, 24'sd0, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd4, 24'sd0, 24'sd3, 24'sd4, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd100, 24'sd1, 24'sd1, 24'sd1, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd5, 24'sd20, 24'sd0, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd6, 24'sd0, 24'sd0, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd7, 24'sd0, 24'sd0, -24'sd30, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd8, 24'sd1, 24'sd2, 24'sd2, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd9, 24'sd0, -24'sd40, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd10, 24'sd6, 24'sd8, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd11, 24'sd50, 24'sd0, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd12, 24'sd0, 24'sd60, 24'sd0, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd13, 24'sd0, 24'sd0, 24'sd60, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd14, 24'sd0, 24'sd0, 24'sd2, 1'b0},
      1'b0, 1'b0, 16'd0},
    '{'{16'd100, 24'sd0, 24'sd0, 24'sd0, 16'd15, 24'sd0, 24'sd0, -24'sd60, 1'b1},
      1'b0, 1'b0, 16'd0},
    // zero distance
    '{'{16'd7, -24'sd1, -24'sd1, -24'sd1, 16'd8, -24'sd1, -24'sd1, -24'sd1, 1'b1},
      1'b1, 1'b1, 16'd8},
    // only self candidates, the last one still closes the list
    '{'{16'd9, 24'sd0, 24'sd0, 24'sd0, 16'd9, 24'sd0, 24'sd0, 24'sd0, 1'b0},
      1'b1, 1'b0, 16'd0},
    '{'{16'd9, 24'sd3, 24'sd0, 24'sd0, 16'd9, 24'sd0, 24'sd0, 24'sd0, 1'b1},
      1'b1, 1'b0, 16'd0}
  };

  // Insert one word into the kept list; on a last word fill ranked[] and clear.
  task automatic rank_candidate(input cand_word_t w, output bit closed);
    longint signed   dx, dy, dz;
    longint unsigned sq_sum;
    int unsigned     pos, k;
    closed = 1'b0;
    if (w.cand_index != w.query_index) begin
      dx = longint'($signed(w.query_x)) - longint'($signed(w.cand_x));
      dy = longint'($signed(w.query_y)) - longint'($signed(w.cand_y));
      dz = longint'($signed(w.query_z)) - longint'($signed(w.cand_z));
      // each square is below 2^50 at this width, so the sum cannot wrap
      sq_sum = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
      pos = 0;
      while (pos < near_cnt && near_dist[pos] <= sq_sum) pos++;
      if (pos < NEIGHBOR_COUNT) begin
        k = (near_cnt < NEIGHBOR_COUNT) ? near_cnt : NEIGHBOR_COUNT - 1;
        for (; k > pos; k--) begin
          near_dist[k] = near_dist[k-1];
          near_idx[k]  = near_idx[k-1];
        end
        near_dist[pos] = sq_sum;
        near_idx[pos]  = w.cand_index;
        if (near_cnt < NEIGHBOR_COUNT) near_cnt++;
      end
    end
    if (w.last) begin
      for (k = 0; k < NEIGHBOR_COUNT; k++) begin
        ranked[k].index = (k < near_cnt) ? RES_BITS'(near_idx[k]) : '0;
        ranked[k].found = (k < near_cnt);
        ranked[k].last  = (k == NEIGHBOR_COUNT - 1);
      end
      near_cnt = 0;
      closed   = 1'b1;
    end
  endtask

  // Drive a word, hold it until taken, then book its expected ranks.
  task automatic send_word(input cand_word_t w, input bit typed, input bit t_found,
                           input logic [RES_BITS-1:0] t_index);
    bit closed;
    int unsigned k;
    rank_t exp_rank;
    start_i          <= 1'b1;
    query_index_i    <= w.query_index;
    query_x_i        <= w.query_x;
    query_y_i        <= w.query_y;
    query_z_i        <= w.query_z;
    cand_index_i     <= w.cand_index;
    cand_x_i         <= w.cand_x;
    cand_y_i         <= w.cand_y;
    cand_z_i         <= w.cand_z;
    last_candidate_i <= w.last;
    do @(posedge clk_i); while (busy_o);
    rank_candidate(w, closed);
    if (closed) begin
      for (k = 0; k < NEIGHBOR_COUNT; k++) begin
        if (typed) begin
          exp_rank.index = (k == 0) ? t_index : '0;
          exp_rank.found = (k == 0) ? t_found : 1'b0;
          exp_rank.last  = (k == NEIGHBOR_COUNT - 1);
        end else begin
          exp_rank = ranked[k];
        end
        pending_ranks.insert(pending_ranks.size(), exp_rank);
      end
    end
  endtask

  // Sender bursts: idle for a while whenever the current burst runs out.
  task automatic pace_sender();
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Hold off the sender until every expected word has come out.
  task automatic drain_results();
    if (pending_ranks.size() != 0) begin
      start_i <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    coord_mode_e mode;
    mode = coord_mode_e'($urandom_range(0, 9) < 6 ? CM_FULL :
                         $urandom_range(0, 9) < 8 ? CM_SMALL :
                         $urandom_range(0, 1) == 0 ? CM_MAX : CM_MIN);
    case (mode)
      CM_FULL:  return COORD_BITS'($urandom());
      CM_SMALL: return COORD_BITS'($urandom_range(0, 16)) - 24'sd8;
      CM_MAX:   return COORD_MAX;
      default:  return COORD_MIN;
    endcase
  endfunction

  // Count and print a mismatch; check_results compares each result with the oldest expectation.
  task automatic note_mismatch(input string what, input rank_t want, input rank_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) begin
      $display("%0t: %s: expected index %h found %b last %b, got index %h found %b last %b",
               $realtime, what, want.index, want.found, want.last,
               got.index, got.found, got.last);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    rank_t want, got;
    if (rst_ni && result_valid_o) begin
      got = '{index: neighbor_index_o, found: found_o, last: last_of_list_o};
      if (pending_ranks.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_ranks.pop_front();
        if (got.index !== want.index || got.found !== want.found ||
            got.last !== want.last) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  initial begin : watchdog
    #1ms;
    $display("k_nearest_neighbor_select test failed");
    $finish;
  end

  initial begin : stimulus
    cand_word_t w;
    logic [INDEX_BITS-1:0]        qi;
    logic signed [COORD_BITS-1:0] qx, qy, qz;
    int unsigned r, n, len, rand_items;
    bit broken, cluster;

    mismatch_cnt = 0;
    burst_left   = 0;
    near_cnt     = 0;
    rand_items   = 0;
    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    query_index_i    <= '0;
    query_x_i        <= '0;
    query_y_i        <= '0;
    query_z_i        <= '0;
    cand_index_i     <= '0;
    cand_x_i         <= '0;
    cand_y_i         <= '0;
    cand_z_i         <= '0;
    last_candidate_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DIR_ROWS; r++) begin
      pace_sender();
      send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].t_found,
                dir_rows[r].t_index);
    end
    drain_results();

    while (rand_items < RAND_ITEMS) begin
      len     = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 14) : $urandom_range(15, 30);
      broken  = ($urandom_range(0, 7) == 0);
      cluster = $urandom_range(0, 1);
      qi = INDEX_BITS'($urandom());
      qx = pick_coord();
      qy = pick_coord();
      qz = pick_coord();
      for (n = 0; n < len; n++) begin
        // broken sequence: query moves and the list may close early
        if (broken) begin
          qi = ($urandom_range(0, 3) == 0) ? qi : INDEX_BITS'($urandom());
          qx = pick_coord();
          qy = pick_coord();
          qz = pick_coord();
        end
        w.query_index = qi;
        w.query_x     = qx;
        w.query_y     = qy;
        w.query_z     = qz;
        w.cand_index  = ($urandom_range(0, 9) == 0) ? qi : INDEX_BITS'($urandom());
        if (cluster) begin
          // near the query so distances tie often
          w.cand_x = qx + COORD_BITS'($urandom_range(0, 6)) - 24'sd3;
          w.cand_y = qy + COORD_BITS'($urandom_range(0, 6)) - 24'sd3;
          w.cand_z = qz + COORD_BITS'($urandom_range(0, 6)) - 24'sd3;
        end else begin
          w.cand_x = pick_coord();
          w.cand_y = pick_coord();
          w.cand_z = pick_coord();
        end
        w.last = (n == len - 1) || (broken && $urandom_range(0, 5) == 0);
        pace_sender();
        send_word(w, 1'b0, 1'b0, '0);
        rand_items++;
      end
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    start_i <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("k_nearest_neighbor_select test passed");
    end else begin
      $display("k_nearest_neighbor_select test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/knn_pkg.sv
hdl/knn_front.sv
hdl/knn_queue.sv
hdl/knn_list.sv
hdl/k_nearest_neighbor_select.sv
bench/tb_k_nearest_neighbor_select.sv
